// ===== design/stereo_source_placement_defines.svh =====
`ifndef STEREO_SOURCE_PLACEMENT_DEFINES_SVH
`define STEREO_SOURCE_PLACEMENT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ssp_pkg.sv =====
package ssp_pkg;

	localparam int W = 32;
	localparam int F = 16;
	localparam int RB = 31;
	localparam int SQN = W + 1;
	localparam int RADW = 2 * SQN;
	localparam int REMW = SQN + 2;
	localparam int NUMW = SQN + RB;
	localparam int BNUMW = W + RB;
	localparam int CFG_IDX_BITS = 3;

	// stage map of the pipeline
	localparam int ST_DIFF = 0;
	localparam int ST_MUL = 1;
	localparam int ST_CROSS = 2;
	localparam int ST_CSQ = 3;
	localparam int ST_CRAD = 4;
	localparam int ST_SQ = 5;
	localparam int ST_TAN = ST_SQ + SQN;
	localparam int ST_SEP = ST_TAN + 1;
	localparam int ST_NUM = ST_SEP + 1;
	localparam int ST_DIV = ST_NUM + 1;
	localparam int ST_POS = ST_DIV + RB;
	localparam int ST_BD = ST_POS + 1;
	localparam int ST_BNUM = ST_BD + 1;
	localparam int ST_BDIV = ST_BNUM + 1;
	localparam int ST_OUT = ST_BDIV + W;
	localparam int DEPTH = ST_OUT + 1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_AMBIENT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSITION = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SEP = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SEP = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TAN_SEP = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT = 3'd5;

	typedef logic signed [W-1:0] word_t;
	typedef logic signed [W:0] dlt_t;
	typedef logic signed [2*W-1:0] prod_t;
	typedef logic [RADW-1:0] rad_t;
	typedef logic [REMW-1:0] rem_t;
	typedef logic [SQN-1:0] len_t;
	typedef logic [RB-1:0] reg_t;
	typedef logic [W-1:0] mag_t;

	localparam reg_t ONE_Q = reg_t'(1) << F;

	typedef enum logic [1:0] {
		ZONE_AMB = 2'd0,
		ZONE_LOC = 2'd1,
		ZONE_BLEND = 2'd2
	} zone_e;

	typedef struct packed {
		reg_t amb;
		reg_t trans;
		reg_t maxs;
		reg_t mins;
		reg_t tans;
		logic left;
	} cfg_t;

	typedef struct packed {
		word_t [2:0] lis;
		word_t [2:0] src;
		word_t [2:0] fac;
		word_t [2:0] upw;
		dlt_t [2:0] dv;
		prod_t [5:0] fu;
		rad_t [2:0] dsq;
		word_t [2:0] cv;
		rad_t [2:0] csq;
		rad_t [2:0] rad;
		rem_t [2:0] rem;
		len_t [2:0] root;
		logic [NUMW-1:0] tprod;
		reg_t sep;
		zone_e zone;
		reg_t [5:0] nlo;
		len_t [5:0] drem;
		reg_t [5:0] quo;
		word_t [2:0] amb;
		word_t [2:0] loc;
		dlt_t [2:0] bd;
		reg_t frac;
		mag_t [2:0] blo;
		reg_t [2:0] brem;
		mag_t [2:0] bquo;
		word_t [2:0] res;
	} item_t;

	function automatic word_t sat_word(input logic signed [2*W:0] v);
		if (v[2*W:W-1] == '0 || v[2*W:W-1] == '1)
			return v[W-1:0];
		return v[2*W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	// work done by stage k on the item it receives
	function automatic item_t ssp_step(input int unsigned k, input item_t p, input cfg_t c);
		item_t n;
		int i;
		logic signed [2*W:0] diff;
		logic [SQN+3:0] stmp;
		logic [SQN+3:0] strial;
		logic [SQN:0] dtmp;
		logic [RB:0] btmp;
		logic [NUMW-1:0] num;
		logic [NUMW-1:0] tsh;
		logic [BNUMW-1:0] bn;
		len_t md;
		len_t dvs;
		mag_t mc;
		reg_t q;
		logic neg;
		logic signed [W+1:0] qx;
		logic signed [W+1:0] sum;
		n = p;
		if (k == ST_DIFF) begin
			for (i = 0; i < 3; i++)
				n.dv[i] = dlt_t'($signed(p.lis[i])) - dlt_t'($signed(p.src[i]));
		end else if (k == ST_MUL) begin
			for (i = 0; i < 3; i++) begin
				md = p.dv[i][W] ? len_t'(-p.dv[i]) : len_t'(p.dv[i]);
				n.dsq[i] = md * md;
			end
			n.fu[0] = $signed(p.fac[1]) * $signed(p.upw[2]);
			n.fu[1] = $signed(p.fac[2]) * $signed(p.upw[1]);
			n.fu[2] = $signed(p.fac[2]) * $signed(p.upw[0]);
			n.fu[3] = $signed(p.fac[0]) * $signed(p.upw[2]);
			n.fu[4] = $signed(p.fac[0]) * $signed(p.upw[1]);
			n.fu[5] = $signed(p.fac[1]) * $signed(p.upw[0]);
		end else if (k == ST_CROSS) begin
			for (i = 0; i < 3; i++) begin
				diff = $signed({p.fu[2*i][2*W-1], p.fu[2*i]})
					- $signed({p.fu[2*i+1][2*W-1], p.fu[2*i+1]});
				n.cv[i] = sat_word(diff >>> F);
			end
			n.rad[0] = p.dsq[0] + p.dsq[1] + p.dsq[2];
			n.rad[2] = p.dsq[0] + p.dsq[1];
		end else if (k == ST_CSQ) begin
			for (i = 0; i < 3; i++) begin
				mc = p.cv[i][W-1] ? mag_t'(-p.cv[i]) : mag_t'(p.cv[i]);
				n.csq[i] = mc * mc;
			end
		end else if (k == ST_CRAD) begin
			n.rad[1] = p.csq[0] + p.csq[1] + p.csq[2];
			n.rem = '0;
			n.root = '0;
		end else if (k >= ST_SQ && k < ST_TAN) begin
			// one root digit per stage for all three lengths
			for (i = 0; i < 3; i++) begin
				stmp = {p.rem[i], p.rad[i][RADW-1 -: 2]};
				strial = {2'b00, p.root[i], 2'b01};
				if (stmp >= strial) begin
					n.rem[i] = rem_t'(stmp - strial);
					n.root[i] = {p.root[i][SQN-2:0], 1'b1};
				end else begin
					n.rem[i] = rem_t'(stmp);
					n.root[i] = {p.root[i][SQN-2:0], 1'b0};
				end
				n.rad[i] = p.rad[i] << 2;
			end
		end else if (k == ST_TAN) begin
			n.tprod = p.root[0] * c.tans;
			if (p.root[0] <= len_t'(c.amb))
				n.zone = ZONE_AMB;
			else if ({1'b0, p.root[0]} >= ((SQN+1)'(c.amb) + (SQN+1)'(c.trans)))
				n.zone = ZONE_LOC;
			else
				n.zone = ZONE_BLEND;
		end else if (k == ST_SEP) begin
			tsh = p.tprod >> F;
			if (tsh > NUMW'(c.maxs))
				n.sep = c.maxs;
			else if (tsh < NUMW'(c.mins))
				n.sep = c.mins;
			else
				n.sep = reg_t'(tsh);
		end else if (k == ST_NUM) begin
			for (i = 0; i < 6; i++) begin
				if (i < 3) begin
					mc = p.cv[i][W-1] ? mag_t'(-p.cv[i]) : mag_t'(p.cv[i]);
					num = mc * c.mins;
				end else if (i == 5) begin
					num = '0;
				end else begin
					md = (i == 3) ? (p.dv[1][W] ? len_t'(-p.dv[1]) : len_t'(p.dv[1]))
						: (p.dv[0][W] ? len_t'(-p.dv[0]) : len_t'(p.dv[0]));
					num = md * p.sep;
				end
				n.drem[i] = num[NUMW-1:RB];
				n.nlo[i] = num[RB-1:0];
				n.quo[i] = '0;
			end
		end else if (k >= ST_DIV && k < ST_POS) begin
			// one quotient bit per stage, six lanes
			for (i = 0; i < 6; i++) begin
				dvs = (i < 3) ? p.root[1] : p.root[2];
				dtmp = {p.drem[i], p.nlo[i][RB-1]};
				if (dtmp >= {1'b0, dvs}) begin
					n.drem[i] = len_t'(dtmp - {1'b0, dvs});
					n.quo[i] = {p.quo[i][RB-2:0], 1'b1};
				end else begin
					n.drem[i] = len_t'(dtmp);
					n.quo[i] = {p.quo[i][RB-2:0], 1'b0};
				end
				n.nlo[i] = p.nlo[i] << 1;
			end
		end else if (k == ST_POS) begin
			for (i = 0; i < 3; i++) begin
				q = (p.root[1] == '0) ? '0 : p.quo[i];
				neg = p.cv[i][W-1] ^ c.left;
				qx = $signed((W+2)'(q));
				sum = $signed({{2{p.lis[i][W-1]}}, p.lis[i]}) + (neg ? -qx : qx);
				n.amb[i] = sat_word((2*W+1)'(sum));
				// sideways vector is (-d.y, d.x, 0)
				if (p.root[2] == '0 || i == 2)
					q = '0;
				else
					q = p.quo[3+i];
				neg = ((i == 0) ? ~p.dv[1][W] : p.dv[0][W]) ^ c.left;
				qx = $signed((W+2)'(q));
				sum = $signed({{2{p.src[i][W-1]}}, p.src[i]}) + (neg ? -qx : qx);
				n.loc[i] = sat_word((2*W+1)'(sum));
			end
		end else if (k == ST_BD) begin
			for (i = 0; i < 3; i++)
				n.bd[i] = dlt_t'($signed(p.loc[i])) - dlt_t'($signed(p.amb[i]));
			n.frac = reg_t'({1'b0, p.root[0]} - (SQN+1)'(c.amb));
		end else if (k == ST_BNUM) begin
			for (i = 0; i < 3; i++) begin
				mc = p.bd[i][W] ? mag_t'(-p.bd[i]) : mag_t'(p.bd[i]);
				bn = mc * p.frac;
				n.brem[i] = bn[BNUMW-1:W];
				n.blo[i] = bn[W-1:0];
				n.bquo[i] = '0;
			end
		end else if (k >= ST_BDIV && k < ST_OUT) begin
			for (i = 0; i < 3; i++) begin
				btmp = {p.brem[i], p.blo[i][W-1]};
				if (btmp >= {1'b0, c.trans}) begin
					n.brem[i] = reg_t'(btmp - {1'b0, c.trans});
					n.bquo[i] = {p.bquo[i][W-2:0], 1'b1};
				end else begin
					n.brem[i] = reg_t'(btmp);
					n.bquo[i] = {p.bquo[i][W-2:0], 1'b0};
				end
				n.blo[i] = p.blo[i] << 1;
			end
		end else if (k == ST_OUT) begin
			for (i = 0; i < 3; i++) begin
				case (p.zone)
					ZONE_AMB: begin
						n.res[i] = p.amb[i];
					end
					ZONE_LOC: begin
						n.res[i] = p.loc[i];
					end
					ZONE_BLEND: begin
						qx = $signed((W+2)'(p.bquo[i]));
						sum = $signed({{2{p.amb[i][W-1]}}, p.amb[i]})
							+ (p.bd[i][W] ? -qx : qx);
						n.res[i] = sat_word((2*W+1)'(sum));
					end
					default: begin
						n.res[i] = p.amb[i];
					end
				endcase
			end
		end
		return n;
	endfunction

endpackage

// ===== design/ssp_if.sv =====
interface ssp_item_if import ssp_pkg::*; ();
	logic valid;
	logic ready;
	word_t listener_x;
	word_t listener_y;
	word_t listener_z;
	word_t facing_x;
	word_t facing_y;
	word_t facing_z;
	word_t upward_x;
	word_t upward_y;
	word_t upward_z;
	word_t source_x;
	word_t source_y;
	word_t source_z;

	modport source (
		output valid, listener_x, listener_y, listener_z, facing_x, facing_y, facing_z,
		output upward_x, upward_y, upward_z, source_x, source_y, source_z,
		input ready
	);
	modport sink (
		input valid, listener_x, listener_y, listener_z, facing_x, facing_y, facing_z,
		input upward_x, upward_y, upward_z, source_x, source_y, source_z,
		output ready
	);
endinterface

interface ssp_result_if import ssp_pkg::*; ();
	logic valid;
	logic ready;
	word_t placed_x;
	word_t placed_y;
	word_t placed_z;
	logic [1:0] zone;

	modport source (output valid, placed_x, placed_y, placed_z, zone, input ready);
	modport sink (input valid, placed_x, placed_y, placed_z, zone, output ready);
endinterface

// ===== design/stereo_source_placement.sv =====
// an input transfer reaches its result through all ssp_pkg::DEPTH stages
// throughput: one item per cycle while the output is not stalled; the depth is
// set by the 33-step root pipeline and the two long-division chains of 31 and
// 32 quotient bits, one bit per stage; each stage holds its item while its
// successor is full and held, so a stalled output only blocks as far back as
// the pipeline is occupied; reset clears all valid bits and loads the register defaults
module stereo_source_placement import ssp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [RB-1:0] cfg_data,
	ssp_item_if.sink item,
	ssp_result_if.source result
);

	cfg_t cfg_q;
	item_t seed;
	item_t stage_in [DEPTH];
	item_t pipe_s [DEPTH];
	logic vld_in [DEPTH];
	logic vld_s [DEPTH];
	logic en [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amb <= '0;
			cfg_q.trans <= ONE_Q;
			cfg_q.maxs <= ONE_Q;
			cfg_q.mins <= '0;
			cfg_q.tans <= ONE_Q;
			cfg_q.left <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AMBIENT: cfg_q.amb <= cfg_data;
				CFG_TRANSITION: cfg_q.trans <= cfg_data;
				CFG_MAX_SEP: cfg_q.maxs <= cfg_data;
				CFG_MIN_SEP: cfg_q.mins <= cfg_data;
				CFG_TAN_SEP: cfg_q.tans <= cfg_data;
				CFG_LEFT: cfg_q.left <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		seed = '0;
		seed.lis = {item.listener_z, item.listener_y, item.listener_x};
		seed.fac = {item.facing_z, item.facing_y, item.facing_x};
		seed.upw = {item.upward_z, item.upward_y, item.upward_x};
		seed.src = {item.source_z, item.source_y, item.source_x};
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		if (k == 0) begin : g_head
			assign stage_in[k] = seed;
			assign vld_in[k] = item.valid;
		end else begin : g_body
			assign stage_in[k] = pipe_s[k-1];
			assign vld_in[k] = vld_s[k-1];
		end

		// a stage loads when empty or when its content moves on
		if (k == DEPTH - 1) begin : g_tail
			assign en[k] = !vld_s[k] || result.ready;
		end else begin : g_mid
			assign en[k] = !vld_s[k] || en[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en[k])
				vld_s[k] <= vld_in[k];
		end

		always_ff @(posedge clk) begin
			if (en[k])
				pipe_s[k] <= ssp_step(k, stage_in[k], cfg_q);
		end
	end

	assign item.ready = en[0];
	assign result.valid = vld_s[DEPTH-1];
	assign result.placed_x = pipe_s[DEPTH-1].res[0];
	assign result.placed_y = pipe_s[DEPTH-1].res[1];
	assign result.placed_z = pipe_s[DEPTH-1].res[2];
	assign result.zone = pipe_s[DEPTH-1].zone;

endmodule

// ===== design/ssp_checker.sv =====
`include "stereo_source_placement_defines.svh"

module ssp_checker import ssp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input word_t placed_x,
	input logic [1:0] zone
);

	localparam int PB = $clog2(DEPTH + 2);

	logic [PB-1:0] pend_q;

	// items accepted whose results have not been taken yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + PB'(item_valid && item_ready) - PB'(result_valid && result_ready);
	end

	`SSP_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(placed_x) && $stable(zone), "stalled result changed")
	`SSP_ASSERT_NOW(a_empty_ready, !result_valid, item_ready, "input blocked with empty output")
	`SSP_ASSERT_NOW(a_no_phantom, result_valid, pend_q != '0, "result without an accepted item")
	`SSP_ASSERT_NOW(a_depth, 1'b1, pend_q <= PB'(DEPTH), "more items in flight than stages")

endmodule

bind stereo_source_placement ssp_checker u_ssp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.placed_x(result.placed_x),
	.zone(result.zone)
);
